[rtl/sag_pkg.sv]
// shared constants, codes and types for the stable argsort and group block
package sag_pkg;

    localparam int SAG_N  = 64;                  // element store depth
    localparam int SAG_IW = $clog2(SAG_N);       // element index width
    localparam int SAG_CW = $clog2(SAG_N + 1);   // count width, holds SAG_N itself
    localparam int SAG_KW = 32;                  // key width
    localparam int SAG_PD = 2 * SAG_N;           // two permutation banks
    localparam int SAG_PW = SAG_IW + 1;          // bank bit plus index

    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_SORT  = 2'd1;
    localparam logic [1:0] KIND_GROUP = 2'd2;
    localparam logic [1:0] KIND_IDENT = 2'd3;

    localparam logic [SAG_CW-1:0] CNT_RESET = SAG_CW'(SAG_N);

    typedef struct packed {
        logic                     load;
        logic                     sort;
        logic                     group;
        logic                     ident;
        logic signed [SAG_KW-1:0] key;
    } t_cmd;

endpackage

[rtl/stable_argsort_and_group.sv]
// top level: stable argsort and grouping of a loaded key set
//
//  channel  direction  handshake          payload
//  request  in         i_valid / o_stall  i_kind, i_key_value
//  result   out        o_valid / i_stall  o_position, o_element_index, o_last
//  config   in         APB write/read     element_count at byte address 0
//
// load and identity requests are handled in the back end's idle state after the queue
// sort: a gather pass, then a rank pass with one value compare per cycle;
//   group adds a first-appearance pass before the rank pass
// each result then passes the emit, capture and hold states and is held through any stall on the result side
// reset is synchronous: identity permutation, load pointer zero, count 64
// a two-entry request queue lets requests arrive while the back end is busy
module stable_argsort_and_group (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [1:0]                        i_kind,
    input  logic signed [sag_pkg::SAG_KW-1:0] i_key_value,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [sag_pkg::SAG_IW-1:0]        o_position,
    output logic [sag_pkg::SAG_IW-1:0]        o_element_index,
    output logic                              o_last,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [2:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    localparam int CW = sag_pkg::SAG_CW;

    logic [CW-1:0] r_count;     // element_count as written
    logic [CW-1:0] act_count;   // count clamped into 1..N
    logic          cfg_we;
    logic          cmd_valid;
    logic          cmd_ready;
    sag_pkg::t_cmd cmd;

    assign pready = 1'b1;
    // only register 0 exists; writes elsewhere are dropped
    assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
    assign prdata = (paddr[2] == 1'b0) ? 32'(r_count) : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= sag_pkg::CNT_RESET;
        end else if (cfg_we) begin
            r_count <= pwdata[CW-1:0];
        end
    end

    // zero counts as one, anything past the store depth as the depth
    always_comb begin
        priority if (r_count == '0) begin
            act_count = CW'(1);
        end else if (r_count > sag_pkg::CNT_RESET) begin
            act_count = sag_pkg::CNT_RESET;
        end else begin
            act_count = r_count;
        end
    end

    sag_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_kind      (i_kind),
        .i_key_value (i_key_value),
        .o_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready),
        .o_cmd       (cmd)
    );

    sag_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_count         (act_count),
        .i_cfg_we        (cfg_we),
        .i_cmd_valid     (cmd_valid),
        .o_cmd_ready     (cmd_ready),
        .i_cmd           (cmd),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_position      (o_position),
        .o_element_index (o_element_index),
        .o_last          (o_last)
    );

endmodule

[rtl/sag_ram.sv]
// generic single write, single registered read memory
module sag_ram #(
    parameter int W = 32,
    parameter int D = 64
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/sag_front.sv]
// front end: request queue and kind decode
module sag_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [1:0]                    i_kind,
    input  logic signed [sag_pkg::SAG_KW-1:0] i_key_value,
    output logic                          o_cmd_valid,
    input  logic                          i_cmd_ready,
    output sag_pkg::t_cmd                 o_cmd
);

    sag_pkg::t_cmd r_q [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;
    sag_pkg::t_cmd dec;
    logic          push;
    logic          pop;

    always_comb begin
        dec       = '0;
        dec.key   = i_key_value;
        unique case (i_kind)
            sag_pkg::KIND_LOAD:  dec.load  = 1'b1;
            sag_pkg::KIND_SORT:  dec.sort  = 1'b1;
            sag_pkg::KIND_GROUP: dec.group = 1'b1;
            sag_pkg::KIND_IDENT: dec.ident = 1'b1;
        endcase
    end

    assign o_stall     = (r_cnt == 2'd2);
    assign push        = i_valid && !o_stall;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign pop         = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= dec;
        end
    end

endmodule

[rtl/sag_back.sv]
// back end: key and permutation stores, rank passes and result emission
module sag_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [sag_pkg::SAG_CW-1:0] i_count,
    input  logic                      i_cfg_we,
    input  logic                      i_cmd_valid,
    output logic                      o_cmd_ready,
    input  sag_pkg::t_cmd             i_cmd,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [sag_pkg::SAG_IW-1:0] o_position,
    output logic [sag_pkg::SAG_IW-1:0] o_element_index,
    output logic                      o_last
);

    localparam int IW = sag_pkg::SAG_IW;
    localparam int CW = sag_pkg::SAG_CW;
    localparam int KW = sag_pkg::SAG_KW;
    localparam int N  = sag_pkg::SAG_N;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_GATHER = 4'd1;
    localparam logic [3:0] ST_OFETCH = 4'd2;
    localparam logic [3:0] ST_OWAIT  = 4'd3;
    localparam logic [3:0] ST_STREAM = 4'd4;
    localparam logic [3:0] ST_FINAL  = 4'd5;
    localparam logic [3:0] ST_EMIT   = 4'd6;
    localparam logic [3:0] ST_ECAP   = 4'd7;
    localparam logic [3:0] ST_EHOLD  = 4'd8;

    logic [3:0]          r_state;
    logic                r_grp;
    logic                r_phase;
    logic                r_bank;
    logic [1:0][N-1:0]   r_pv;
    logic [IW-1:0]       r_lp;
    logic [CW-1:0]       r_gi;
    logic                r_g1_v;
    logic [IW-1:0]       r_g1_i;
    logic                r_g2_v;
    logic [IW-1:0]       r_g2_i;
    logic [CW-1:0]       r_i;
    logic [CW-1:0]       r_j;
    logic [CW-1:0]       r_k;
    logic                r_s_v;
    logic [IW-1:0]       r_s_j;
    logic [KW-1:0]       r_vi;
    logic [IW-1:0]       r_pi;
    logic [IW-1:0]       r_acc;
    logic                r_found;
    logic [IW-1:0]       r_f;
    logic [IW-1:0]       r_prd_idx;
    logic                r_prd_pv;
    logic                r_o_valid;
    logic [IW-1:0]       r_o_pos;
    logic [IW-1:0]       r_o_idx;
    logic                r_o_last;

    logic                cmd_take;
    logic [IW-1:0]       lp_eff;
    logic [CW-1:0]       lp_inc;
    logic [IW-1:0]       n_lp;
    logic [IW-1:0]       perm_ridx;
    logic [IW-1:0]       perm_rdata;
    logic [IW-1:0]       p_val;
    logic                perm_we;
    logic [KW-1:0]       key_rdata;
    logic                key_we;
    logic                v_we;
    logic                w_we;
    logic [IW-1:0]       w_waddr;
    logic [KW-1:0]       w_wdata;
    logic [KW-1:0]       va_rdata;
    logic [KW-1:0]       vb_rdata;
    logic [KW-1:0]       wa_rdata;
    logic [KW-1:0]       wb_rdata;
    logic [KW-1:0]       src_a;
    logic [KW-1:0]       src_b;
    logic                eq;
    logic                lt;
    logic [CW-1:0]       i_next;

    assign o_cmd_ready = (r_state == ST_IDLE);
    assign cmd_take    = i_cmd_valid && o_cmd_ready;

    // load pointer wraps at the count
    assign lp_eff = ({1'b0, r_lp} >= i_count) ? '0 : r_lp;
    assign lp_inc = {1'b0, lp_eff} + CW'(1);
    assign n_lp   = (lp_inc >= i_count) ? '0 : lp_inc[IW-1:0];

    assign key_we = cmd_take && i_cmd.load;

    // unwritten permutation entries read as their own index
    assign p_val = r_prd_pv ? perm_rdata : r_prd_idx;

    always_comb begin
        unique case (r_state)
            ST_OFETCH, ST_OWAIT, ST_STREAM, ST_FINAL: perm_ridx = r_i[IW-1:0];
            ST_EMIT, ST_ECAP, ST_EHOLD:               perm_ridx = r_k[IW-1:0];
            default:                                  perm_ridx = r_gi[IW-1:0];
        endcase
    end

    assign perm_we = (r_state == ST_FINAL) && r_phase;
    assign v_we    = r_g2_v && r_grp;
    assign w_we    = (r_g2_v && !r_grp) || ((r_state == ST_FINAL) && !r_phase);
    assign w_waddr = r_g2_v ? r_g2_i : r_i[IW-1:0];
    assign w_wdata = r_g2_v ? key_rdata : KW'(r_f);

    assign src_a  = r_phase ? wa_rdata : va_rdata;
    assign src_b  = r_phase ? wb_rdata : vb_rdata;
    assign eq     = (src_b == r_vi);
    assign lt     = ($signed(src_b) < $signed(r_vi));
    assign i_next = r_i + CW'(1);

    sag_ram #(.W(KW), .D(N)) u_key (
        .i_clk(i_clk), .i_we(key_we), .i_waddr(lp_eff), .i_wdata(i_cmd.key),
        .i_raddr(p_val), .o_rdata(key_rdata)
    );

    sag_ram #(.W(IW), .D(sag_pkg::SAG_PD)) u_perm (
        .i_clk(i_clk), .i_we(perm_we), .i_waddr({~r_bank, r_acc}), .i_wdata(r_pi),
        .i_raddr({r_bank, perm_ridx}), .o_rdata(perm_rdata)
    );

    sag_ram #(.W(KW), .D(N)) u_va (
        .i_clk(i_clk), .i_we(v_we), .i_waddr(r_g2_i), .i_wdata(key_rdata),
        .i_raddr(r_i[IW-1:0]), .o_rdata(va_rdata)
    );

    sag_ram #(.W(KW), .D(N)) u_vb (
        .i_clk(i_clk), .i_we(v_we), .i_waddr(r_g2_i), .i_wdata(key_rdata),
        .i_raddr(r_j[IW-1:0]), .o_rdata(vb_rdata)
    );

    sag_ram #(.W(KW), .D(N)) u_wa (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(r_i[IW-1:0]), .o_rdata(wa_rdata)
    );

    sag_ram #(.W(KW), .D(N)) u_wb (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(r_j[IW-1:0]), .o_rdata(wb_rdata)
    );

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_grp     <= 1'b0;
            r_phase   <= 1'b0;
            r_bank    <= 1'b0;
            r_pv      <= '0;
            r_lp      <= '0;
            r_gi      <= '0;
            r_g1_v    <= 1'b0;
            r_g2_v    <= 1'b0;
            r_i       <= '0;
            r_j       <= '0;
            r_k       <= '0;
            r_s_v     <= 1'b0;
            r_acc     <= '0;
            r_found   <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_pv <= '0;
                r_lp <= '0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (cmd_take) begin
                        if (i_cmd.load) begin
                            r_lp <= n_lp;
                        end
                        if (i_cmd.ident) begin
                            r_pv <= '0;
                        end
                        if (i_cmd.sort || i_cmd.group) begin
                            r_grp   <= i_cmd.group;
                            r_gi    <= '0;
                            r_g1_v  <= 1'b0;
                            r_g2_v  <= 1'b0;
                            r_state <= ST_GATHER;
                        end
                    end
                end
                ST_GATHER: begin
                    // permutation read, key read, copy to va/vb (wa/wb for sort)
                    r_g1_v <= (r_gi < i_count);
                    if (r_gi < i_count) begin
                        r_gi <= r_gi + CW'(1);
                    end
                    r_g2_v <= r_g1_v;
                    if ((r_gi == i_count) && !r_g1_v && !r_g2_v) begin
                        r_i     <= '0;
                        r_phase <= !r_grp;
                        r_state <= ST_OFETCH;
                    end
                end
                ST_OFETCH: begin
                    r_state <= ST_OWAIT;
                end
                ST_OWAIT: begin
                    r_j     <= '0;
                    r_s_v   <= 1'b0;
                    r_acc   <= '0;
                    r_found <= 1'b0;
                    r_state <= ST_STREAM;
                end
                ST_STREAM: begin
                    r_s_v <= (r_j < i_count);
                    if (r_j < i_count) begin
                        r_j <= r_j + CW'(1);
                    end
                    if (r_s_v) begin
                        if (r_phase) begin
                            if (lt || (eq && (r_s_j < r_i[IW-1:0]))) begin
                                r_acc <= r_acc + IW'(1);
                            end
                        end else if (!r_found && eq) begin
                            r_found <= 1'b1;
                        end
                    end
                    if ((r_j == i_count) && !r_s_v) begin
                        r_state <= ST_FINAL;
                    end
                end
                ST_FINAL: begin
                    if (r_phase) begin
                        r_pv[~r_bank][r_acc] <= 1'b1;
                    end
                    if (i_next == i_count) begin
                        r_i <= '0;
                        if (r_phase) begin
                            r_bank  <= ~r_bank;
                            r_k     <= '0;
                            r_state <= ST_EMIT;
                        end else begin
                            r_phase <= 1'b1;
                            r_state <= ST_OFETCH;
                        end
                    end else begin
                        r_i     <= i_next;
                        r_state <= ST_OFETCH;
                    end
                end
                ST_EMIT: begin
                    r_state <= ST_ECAP;
                end
                ST_ECAP: begin
                    r_o_valid <= 1'b1;
                    r_state   <= ST_EHOLD;
                end
                ST_EHOLD: begin
                    if (!i_stall) begin
                        r_o_valid <= 1'b0;
                        if (r_o_last) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_k     <= r_k + CW'(1);
                            r_state <= ST_EMIT;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_prd_idx <= perm_ridx;
        r_prd_pv  <= r_pv[r_bank][perm_ridx];
        r_g1_i    <= r_gi[IW-1:0];
        r_g2_i    <= r_g1_i;
        r_s_j     <= r_j[IW-1:0];
        if (r_state == ST_OWAIT) begin
            r_vi <= src_a;
            r_pi <= p_val;
        end
        if ((r_state == ST_STREAM) && r_s_v && !r_phase && !r_found && eq) begin
            r_f <= r_s_j;
        end
        if (r_state == ST_ECAP) begin
            r_o_pos  <= r_k[IW-1:0];
            r_o_idx  <= p_val;
            r_o_last <= ((r_k + CW'(1)) == i_count);
        end
    end

    assign o_valid         = r_o_valid;
    assign o_position      = r_o_pos;
    assign o_element_index = r_o_idx;
    assign o_last          = r_o_last;

endmodule
